/* hw/rtl/bmp_rle4_line_decoder_core_macros.svh */
// Assertion macros shared by the RLE4 line decoder RTL.
`ifndef BMP_RLE4_LINE_DECODER_CORE_MACROS_SVH
`define BMP_RLE4_LINE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define BRLE4_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("brle4 same-cycle check failed");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define BRLE4_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("brle4 next-cycle check failed");

`endif

/* hw/rtl/brle4_pkg.sv */
// Types, constants and codes shared by the RLE4 line decoder modules.
package brle4_pkg;

    localparam int OUT_BYTES = 8;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int DATA_W    = OUT_BYTES * BYTE_W;
    localparam int CNT_W     = $clog2(OUT_BYTES + 1);
    localparam int IDX_W     = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
    localparam int EVT_W     = 2;
    localparam int RES_W     = DATA_W + CNT_W + EVT_W;
    localparam int TDATA_W   = ((RES_W + 7) / 8) * 8;

    // Second byte of an escape sequence.
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // Number of bytes skipped after a delta escape.
    localparam logic [1:0] DELTA_SKIP = 2'd2;

    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_ESC    = 3'd1,
        PH_COLOUR = 3'd2,
        PH_SKIP   = 3'd3,
        PH_ABS    = 3'd4
    } phase_t;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE = 2'd0,
        EV_EOL  = 2'd1,
        EV_EOB  = 2'd2,
        EV_END  = 2'd3
    } line_event_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_STEP = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic emit;
    } dp_status_t;

    // One result transaction.
    typedef struct packed {
        line_event_t        evt;
        logic [CNT_W-1:0]   count;
        logic [DATA_W-1:0]  data;
        logic               last;
    } result_t;

endpackage

/* hw/rtl/brle4_ctrl.sv */
// Controller state machine: accepts one input transaction and steps the datapath.
module brle4_ctrl
    import brle4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_free,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A step that produces a result waits for the output slot.
    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_STEP;
                end
            end
            CS_STEP: begin
                cmd.step = !status.emit || out_free;
                if (cmd.step && status.done) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/brle4_dpath.sv */
// Datapath: parser state, nibble pairing and result byte accumulation.
module brle4_dpath
    import brle4_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    output result_t           res
);

    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;

    phase_t            phase_reg, phase_next;
    logic [7:0]        rl_reg, rl_next;
    logic [7:0]        abs_total_reg, abs_total_next;
    logic [8:0]        abs_idx_reg, abs_idx_next;
    logic [1:0]        skip_reg, skip_next;
    logic [NIB_W-1:0]  pnib_reg, pnib_next;
    logic              pv_reg, pv_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [1:0]        nib_n;
    logic [NIB_W-1:0]  nib_a, nib_b;
    line_event_t       evt;
    logic              done;
    logic              drop;
    logic [1:0]        take;
    logic              abs_hi, abs_lo;
    logic [8:0]        abs_sum;
    logic [8:0]        abs_limit;

    logic              byte_v;
    logic [BYTE_W-1:0] byte_val;
    logic [DATA_W-1:0] acc_after;
    logic [CNT_W-1:0]  cnt_after;
    logic              more;
    logic              emit;

    // Input holding register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            end_reg  <= in_end;
        end
    end

    // Parser: nibbles produced by this step, the event and the next parse state.
    always_comb begin
        phase_next     = phase_reg;
        rl_next        = rl_reg;
        abs_total_next = abs_total_reg;
        abs_idx_next   = abs_idx_reg;
        skip_next      = skip_reg;
        nib_n          = 2'd0;
        nib_a          = byte_reg[7:4];
        nib_b          = byte_reg[3:0];
        evt            = EV_NONE;
        done           = 1'b1;
        drop           = 1'b0;
        take           = (rl_reg >= 8'd2) ? 2'd2 : rl_reg[1:0];
        abs_hi         = abs_idx_reg < {1'b0, abs_total_reg};
        abs_lo         = ({1'b0, abs_idx_reg} + 10'd1) < {2'b0, abs_total_reg};
        abs_sum        = abs_idx_reg + 9'd2;
        abs_limit      = ({1'b0, abs_total_reg} + 9'd3) & ~9'd3;
        if (end_reg) begin
            // Input exhausted: parser back to reset, half byte dropped.
            phase_next     = PH_COUNT;
            rl_next        = 8'd0;
            abs_total_next = 8'd0;
            abs_idx_next   = 9'd0;
            skip_next      = 2'd0;
            drop           = 1'b1;
            evt            = EV_END;
        end else begin
            case (phase_reg)
                PH_ESC: begin
                    if (byte_reg == ESC_EOL || byte_reg == ESC_EOB) begin
                        // Flush a half-filled byte with a zero low nibble.
                        nib_n      = {1'b0, pv_reg};
                        nib_a      = '0;
                        evt        = (byte_reg == ESC_EOB) ? EV_EOB : EV_EOL;
                        phase_next = PH_COUNT;
                    end else if (byte_reg == ESC_DELTA) begin
                        skip_next  = DELTA_SKIP;
                        phase_next = PH_SKIP;
                    end else begin
                        abs_total_next = byte_reg;
                        abs_idx_next   = 9'd0;
                        phase_next     = PH_ABS;
                    end
                end
                PH_COLOUR: begin
                    // Up to two nibbles of the run per step, high nibble first.
                    nib_n   = take;
                    rl_next = rl_reg - {6'd0, take};
                    done    = rl_reg <= 8'd2;
                    if (done) begin
                        rl_next    = 8'd0;
                        phase_next = PH_COUNT;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 2'd1;
                    if (skip_reg == 2'd1) begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_ABS: begin
                    nib_n        = {1'b0, abs_hi} + {1'b0, abs_lo};
                    abs_idx_next = abs_sum;
                    if (abs_sum >= abs_limit) begin
                        abs_idx_next   = 9'd0;
                        abs_total_next = 8'd0;
                        phase_next     = PH_COUNT;
                    end
                end
                default: begin
                    if (byte_reg == '0) begin
                        phase_next = PH_ESC;
                    end else begin
                        rl_next    = byte_reg;
                        phase_next = PH_COLOUR;
                    end
                end
            endcase
        end
    end

    // Nibble pairing: at most one finished byte per step.
    always_comb begin
        byte_v    = 1'b0;
        byte_val  = {pnib_reg, nib_a};
        pv_next   = pv_reg;
        pnib_next = pnib_reg;
        if (!pv_reg) begin
            if (nib_n == 2'd1) begin
                pv_next   = 1'b1;
                pnib_next = nib_a;
            end else if (nib_n == 2'd2) begin
                byte_v   = 1'b1;
                byte_val = {nib_a, nib_b};
            end
        end else if (nib_n != 2'd0) begin
            byte_v = 1'b1;
            if (nib_n == 2'd2) begin
                pnib_next = nib_b;
            end else begin
                pv_next   = 1'b0;
                pnib_next = '0;
            end
        end
        if (drop) begin
            pv_next   = 1'b0;
            pnib_next = '0;
        end
    end

    // Result accumulation. A full group goes out early only if more bytes follow.
    always_comb begin
        acc_after = acc_reg;
        if (byte_v) begin
            acc_after[cnt_reg[IDX_W-1:0]*BYTE_W +: BYTE_W] = byte_val;
        end
        cnt_after = cnt_reg + {{(CNT_W-1){1'b0}}, byte_v};
        more      = (rl_next >= 8'd2) || (rl_next == 8'd1 && pv_next);
        emit      = (cnt_after == CNT_W'(OUT_BYTES) && !done && more)
                 || (done && (cnt_after != '0 || evt != EV_NONE));
        acc_next  = emit ? '0 : acc_after;
        cnt_next  = emit ? '0 : cnt_after;
    end

    assign status.done = done;
    assign status.emit = emit;
    assign res.data    = acc_after;
    assign res.count   = cnt_after;
    assign res.evt     = done ? evt : EV_NONE;
    assign res.last    = done;

    // Parser and accumulator registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COUNT;
            rl_reg        <= 8'd0;
            abs_total_reg <= 8'd0;
            abs_idx_reg   <= 9'd0;
            skip_reg      <= 2'd0;
            pnib_reg      <= '0;
            pv_reg        <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end else if (cmd.step) begin
            phase_reg     <= phase_next;
            rl_reg        <= rl_next;
            abs_total_reg <= abs_total_next;
            abs_idx_reg   <= abs_idx_next;
            skip_reg      <= skip_next;
            pnib_reg      <= pnib_next;
            pv_reg        <= pv_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

/* hw/rtl/brle4_ostage.sv */
// Output register that holds one result transaction until it is taken.
module brle4_ostage
    import brle4_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    // Valid flag: set on load, cleared when the transaction is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

/* hw/rtl/bmp_rle4_line_decoder_core.sv */
// Flow: an accepted byte is held in the input register, the datapath steps on it, and a
// result is registered in the output stage. No new compressed byte is taken until the
// current one is done. The parser steps a colour byte of a run at most two pixels a
// cycle, and output back-pressure stalls only steps that produce a result.
// Reset: synchronous, active low; clears the parser state, the half byte and the output.
`include "bmp_rle4_line_decoder_core_macros.svh"

module bmp_rle4_line_decoder_core
    import brle4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic               s_tuser,   // [0] stream_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [63:0] packed_bytes, [67:64] byte_count,
                                          // [69:68] line_event, [71:70] zero
    output logic               m_tlast    // last_result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    result_t    dp_res;
    result_t    out_res;
    logic       out_free;

    brle4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    brle4_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_tdata),
        .in_end  (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .res     (dp_res)
    );

    brle4_ostage u_ostage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cmd.step && status.emit),
        .res_in    (dp_res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (out_res)
    );

    // Pack the result fields into the stream data word.
    assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, out_res.evt, out_res.count, out_res.data};
    assign m_tlast = out_res.last;

    // A result without bytes only closes an item.
    `BRLE4_ASSERT_IMP(a_empty_is_final, m_tvalid && out_res.count == '0, m_tlast)
    // Results before the final one are full groups without an event.
    `BRLE4_ASSERT_IMP(a_early_full, m_tvalid && !m_tlast,
        out_res.count == CNT_W'(OUT_BYTES) && out_res.evt == EV_NONE)
    // After an accepted transaction the decoder works on it before taking another.
    `BRLE4_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule
